>>> rtl/fccw_pkg.sv
// Package: shared widths, codes and defaults for the FAT12 cluster chain walker.
package fccw_pkg;

	localparam int unsigned TABLE_BYTES_DEF = 8192;
	localparam int unsigned MAX_CHAIN_DEF   = 64;

	localparam int unsigned CLUSTER_W = 12;
	localparam int unsigned TADDR_W   = 13;
	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned LBA_W     = 32;
	localparam int unsigned SPC_W     = 8;
	localparam int unsigned CFG_IDX_W = 1;

	// signed (cluster - 2) times sectors per cluster, zero-extended to signed
	localparam int unsigned DIFF_W = CLUSTER_W + 1;
	localparam int unsigned PROD_W = DIFF_W + SPC_W + 1;

	localparam logic [CLUSTER_W-1:0] END_MARK = 12'hFF8;
	localparam logic [CLUSTER_W-1:0] MASK12   = 12'hFFF;

	localparam logic [LBA_W-1:0] DATA_START_RST = 32'd33;
	localparam logic [SPC_W-1:0] SPC_RST        = 8'd1;

	typedef enum logic {
		CMD_LOAD = 1'b0,
		CMD_WALK = 1'b1
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DATA_START = 1'b0,
		REG_SPC        = 1'b1
	} reg_idx_t;

endpackage

>>> rtl/fccw_if.sv
// Interfaces: request and response channels of the cluster chain walker.
interface fccw_req_if;
	logic                             valid;
	logic                             ready;
	logic                             cmd;
	logic [fccw_pkg::TADDR_W-1:0]     table_addr;
	logic [fccw_pkg::BYTE_W-1:0]      table_byte;
	logic [fccw_pkg::CLUSTER_W-1:0]   start_cluster;

	modport source(output valid, cmd, table_addr, table_byte, start_cluster, input ready);
	modport sink(input valid, cmd, table_addr, table_byte, start_cluster, output ready);
endinterface

interface fccw_rsp_if;
	logic                             valid;
	logic                             ready;
	logic [fccw_pkg::LBA_W-1:0]       sector_addr;
	logic [fccw_pkg::CLUSTER_W-1:0]   cluster_num;
	logic                             last;
	logic                             truncated;

	modport source(output valid, sector_addr, cluster_num, last, truncated, input ready);
	modport sink(input valid, sector_addr, cluster_num, last, truncated, output ready);
endinterface

>>> rtl/fat12_cluster_chain_walker_core.sv
// Top level: FAT12 cluster chain walker with its table byte store.
// Operation: a load transaction is taken in the idle state; a walk is accepted
// there, then each cluster passes a low-byte read and a high-byte read of the
// single-port table memory and a result state, which holds while the response
// side stalls. Up to MAX_CHAIN results; no new request is taken until the walk ends.
// Reset (arst_n, async, active low) clears control state, configuration registers
// and the output valid flag; the table memory is not cleared and holds garbage until loaded.
module fat12_cluster_chain_walker_core #(
	parameter int unsigned TABLE_BYTES = fccw_pkg::TABLE_BYTES_DEF,
	parameter int unsigned MAX_CHAIN   = fccw_pkg::MAX_CHAIN_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [fccw_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [fccw_pkg::LBA_W-1:0]      cfg_wdata,
	fccw_req_if.sink                        req,
	fccw_rsp_if.source                      rsp
);

	localparam int unsigned AW = $clog2(TABLE_BYTES);
	localparam int unsigned SW = (MAX_CHAIN > 1) ? $clog2(MAX_CHAIN) : 1;
	localparam logic [SW-1:0] STEP_LAST = SW'(MAX_CHAIN - 1);

	// One-hot sequencer: idle, read low byte, read high byte, form result.
	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_RD_LO = 4'b0010,
		S_RD_HI = 4'b0100,
		S_NEXT  = 4'b1000
	} state_t;

	state_t                               state_q;
	logic [fccw_pkg::CLUSTER_W-1:0]       cur_q;
	logic [SW-1:0]                        steps_q;
	logic [fccw_pkg::LBA_W-1:0]           lba_q;
	logic [fccw_pkg::SPC_W-1:0]           spc_q;
	logic signed [fccw_pkg::PROD_W-1:0]   prod_q;
	logic [fccw_pkg::LBA_W-1:0]           sector_q;
	logic [fccw_pkg::BYTE_W-1:0]          lo_q;
	logic [fccw_pkg::BYTE_W-1:0]          rdata_q;
	logic                                 rsp_valid_q;
	logic [fccw_pkg::LBA_W-1:0]           rsp_sector_q;
	logic [fccw_pkg::CLUSTER_W-1:0]       rsp_cluster_q;
	logic                                 rsp_last_q;
	logic                                 rsp_trunc_q;

	logic [fccw_pkg::BYTE_W-1:0]          mem [TABLE_BYTES];

	logic                                 req_acc;
	logic                                 mem_we;
	logic [AW-1:0]                        raddr;
	logic [fccw_pkg::TADDR_W-1:0]         off;
	logic signed [fccw_pkg::DIFF_W-1:0]   diff;
	logic [2*fccw_pkg::BYTE_W-1:0]        word;
	logic [fccw_pkg::CLUSTER_W-1:0]       nxt;
	logic                                 at_end;
	logic                                 cut;
	logic                                 out_load;

	assign req.ready = (state_q == S_IDLE);
	assign req_acc   = req.valid && req.ready;

	// Drop loads that land beyond the store.
	assign mem_we = req_acc && (req.cmd == fccw_pkg::CMD_LOAD)
		&& (32'(req.table_addr) < 32'(TABLE_BYTES));

	// Byte offset of the 12-bit entry: cluster * 3 / 2.
	assign off   = fccw_pkg::TADDR_W'(cur_q) + fccw_pkg::TADDR_W'(cur_q >> 1);
	assign raddr = (state_q == S_RD_HI) ? AW'(off + fccw_pkg::TADDR_W'(1)) : AW'(off);

	// Multiplier operand: cluster minus two, may go negative.
	assign diff = $signed({1'b0, cur_q}) - $signed(fccw_pkg::DIFF_W'(2));

	// Little-endian word; odd clusters sit in the upper 12 bits.
	assign word   = {rdata_q, lo_q};
	assign nxt    = cur_q[0] ? word[15:4] : (word[11:0] & fccw_pkg::MASK12);
	assign at_end = (nxt >= fccw_pkg::END_MARK);
	assign cut    = !at_end && (steps_q == STEP_LAST);

	// Output register is free when empty or being drained this cycle.
	assign out_load = (state_q == S_NEXT) && (!rsp_valid_q || rsp.ready);

	// Table memory: one write or one read per cycle, registered read data.
	// Hold the high byte while the result waits for the output register.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[AW'(req.table_addr)] <= req.table_byte;
		end
		if ((state_q == S_RD_LO) || (state_q == S_RD_HI)) begin
			rdata_q <= mem[raddr];
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lba_q <= fccw_pkg::DATA_START_RST;
			spc_q <= fccw_pkg::SPC_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				fccw_pkg::REG_DATA_START: lba_q <= cfg_wdata;
				fccw_pkg::REG_SPC:        spc_q <= cfg_wdata[fccw_pkg::SPC_W-1:0];
				default: ;
			endcase
		end
	end

	// Arithmetic datapath: multiply while reading the low byte, add while
	// reading the high byte, so the sector is ready with the next cluster.
	always_ff @(posedge clk) begin
		if (state_q == S_RD_LO) begin
			prod_q <= diff * $signed({1'b0, spc_q});
		end
		if (state_q == S_RD_HI) begin
			lo_q     <= rdata_q;
			sector_q <= lba_q + {{(fccw_pkg::LBA_W - fccw_pkg::PROD_W){prod_q[fccw_pkg::PROD_W-1]}},
				prod_q};
		end
	end

	// Sequencer: walk the chain one cluster at a time.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cur_q   <= '0;
			steps_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_acc && (req.cmd == fccw_pkg::CMD_WALK)) begin
						cur_q   <= req.start_cluster;
						steps_q <= '0;
						state_q <= S_RD_LO;
					end
				end
				S_RD_LO: state_q <= S_RD_HI;
				S_RD_HI: state_q <= S_NEXT;
				S_NEXT: begin
					// Hold here until the output register can take the result.
					if (out_load) begin
						if (at_end || cut) begin
							state_q <= S_IDLE;
						end else begin
							cur_q   <= nxt;
							steps_q <= steps_q + SW'(1);
							state_q <= S_RD_LO;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Output register: valid flag under reset, payload without.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			rsp_sector_q  <= sector_q;
			rsp_cluster_q <= cur_q;
			rsp_last_q    <= at_end || cut;
			rsp_trunc_q   <= cut;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.sector_addr = rsp_sector_q;
	assign rsp.cluster_num = rsp_cluster_q;
	assign rsp.last        = rsp_last_q;
	assign rsp.truncated   = rsp_trunc_q;

`ifndef NO_ASSERTIONS
	// A cut-off walk always closes with the last flag.
	a_trunc_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> (!rsp_trunc_q || rsp_last_q))
		else $error("truncated result without last");

	// Step count never passes the chain bound.
	a_steps_bound: assert property (@(posedge clk) disable iff (!arst_n)
		steps_q <= STEP_LAST)
		else $error("step count beyond chain bound");

	// An accepted walk starts a fresh count at the low-byte read.
	a_walk_start: assert property (@(posedge clk) disable iff (!arst_n)
		(req_acc && req.cmd == fccw_pkg::CMD_WALK) |=> (state_q == S_RD_LO && steps_q == '0))
		else $error("walk did not start cleanly");
`endif

endmodule

>>> test/tb_fat12_cluster_chain_walker_core.sv
// Testbench: directed and random regression of the FAT12 cluster chain walker core.
import fccw_pkg::*;

typedef struct packed {
	logic [LBA_W-1:0]     sector_addr;
	logic [CLUSTER_W-1:0] cluster_num;
	logic                 last;
	logic                 truncated;
} cluster_visit_t;

class chain_scoreboard;
	logic [BYTE_W-1:0] fat_bytes [TABLE_BYTES_DEF];
	bit                loaded [TABLE_BYTES_DEF];
	logic [LBA_W-1:0]  data_start;
	logic [SPC_W-1:0]  spc;
	cluster_visit_t    visits_due [$];
	int unsigned       mismatches;

	function new();
		data_start = DATA_START_RST;
		spc = SPC_RST;
		mismatches = 0;
		foreach (loaded[i])
			loaded[i] = 1'b0;
	endfunction

	function void report(string what);
		mismatches++;
		$display("mismatch: %s", what);
	endfunction

	function void write_reg(reg_idx_t idx, logic [LBA_W-1:0] value);
		case (idx)
		REG_DATA_START: data_start = value;
		REG_SPC: spc = value[SPC_W-1:0];
		endcase
	endfunction

	function logic [BYTE_W-1:0] byte_at(int unsigned a);
		return (a < TABLE_BYTES_DEF) ? fat_bytes[a] : '0;
	endfunction

	// 12-bit entry packed two per three bytes, little endian
	function logic [CLUSTER_W-1:0] fat_entry(logic [CLUSTER_W-1:0] c);
		int unsigned off;
		logic [15:0] word;
		off = 32'(c) * 3 / 2;
		word = {byte_at(off + 1), byte_at(off)};
		return c[0] ? word[15:4] : word[11:0];
	endfunction

	// true when every table byte the walk will read has been loaded
	function bit chain_is_loaded(logic [CLUSTER_W-1:0] start);
		logic [CLUSTER_W-1:0] c;
		int unsigned off;
		c = start;
		for (int n = 0; n < MAX_CHAIN_DEF; n++) begin
			off = 32'(c) * 3 / 2;
			if (!loaded[off] || !loaded[off + 1])
				return 1'b0;
			c = fat_entry(c);
			if (c >= END_MARK)
				return 1'b1;
		end
		return 1'b1;
	endfunction

	function void predict_walk(logic [CLUSTER_W-1:0] start);
		logic [CLUSTER_W-1:0] c;
		logic [CLUSTER_W-1:0] nxt;
		int unsigned steps;
		bit at_end;
		bit cut;
		cluster_visit_t v;
		c = start;
		steps = 0;
		forever begin
			v.sector_addr = data_start + (32'(c) - 32'd2) * 32'(spc);
			nxt = fat_entry(c);
			at_end = (nxt >= END_MARK);
			steps++;
			cut = !at_end && (steps >= MAX_CHAIN_DEF);
			v.cluster_num = c;
			v.last = at_end || cut;
			v.truncated = cut;
			visits_due.push_back(v);
			c = nxt;
			if (at_end || cut)
				break;
		end
	endfunction

	function void note_request(cmd_t cmd, logic [TADDR_W-1:0] addr, logic [BYTE_W-1:0] data,
			logic [CLUSTER_W-1:0] start);
		if (cmd == CMD_LOAD) begin
			if (addr < TABLE_BYTES_DEF) begin
				fat_bytes[addr] = data;
				loaded[addr] = 1'b1;
			end
		end else begin
			predict_walk(start);
		end
	endfunction

	function void check_visit(cluster_visit_t got);
		cluster_visit_t want;
		if (visits_due.size() == 0) begin
			report($sformatf("unexpected visit of cluster %03h", got.cluster_num));
			return;
		end
		want = visits_due.pop_front();
		if (got.sector_addr !== want.sector_addr)
			report($sformatf("cluster %03h sector_addr %08h, want %08h",
				want.cluster_num, got.sector_addr, want.sector_addr));
		if (got.cluster_num !== want.cluster_num)
			report($sformatf("cluster_num %03h, want %03h", got.cluster_num, want.cluster_num));
		if (got.last !== want.last)
			report($sformatf("cluster %03h last %b, want %b",
				want.cluster_num, got.last, want.last));
		if (got.truncated !== want.truncated)
			report($sformatf("cluster %03h truncated %b, want %b",
				want.cluster_num, got.truncated, want.truncated));
	endfunction

	function void check_drained();
		if (visits_due.size() != 0)
			report($sformatf("%0d visits never reported", visits_due.size()));
	endfunction
endclass

module tb_fat12_cluster_chain_walker_core;
	timeunit 1ns;
	timeprecision 1ps;

	// cycles without any transaction before the run is declared hung
	localparam int unsigned STALL_LIMIT   = 2000;
	// quiet cycles after the last visit so the walker settles before a register write
	localparam int unsigned SETTLE_CYCLES = 6;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [LBA_W-1:0]     cfg_wdata;

	fccw_req_if req_ch();
	fccw_rsp_if rsp_ch();

	fat12_cluster_chain_walker_core u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_wdata(cfg_wdata),
		.req      (req_ch),
		.rsp      (rsp_ch)
	);

	chain_scoreboard      sb = new();
	bit                   calm = 1'b0;     // no idling on either side while set
	int unsigned          req_count = 0;
	int unsigned          stall_cycles = 0;
	logic [CLUSTER_W-1:0] chain_nodes [$];
	logic [CLUSTER_W-1:0] used_clusters [$];

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic int unsigned pick_gap();
		return calm ? 0 : $urandom_range(0, 4);
	endfunction

	// Watchdog: any transaction on either channel restarts the count.
	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("fat12_cluster_chain_walker_core regression: fail");
			$finish;
		end
	end

	// Response side: check each accepted transaction, then draw the stall before the next.
	// Ready is touched once per edge, so a ready that stays high is never pulsed.
	initial begin : response_side
		int unsigned hold;
		cluster_visit_t got;
		hold = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
				got = {rsp_ch.sector_addr, rsp_ch.cluster_num, rsp_ch.last, rsp_ch.truncated};
				sb.check_visit(got);
				hold = pick_gap();
			end
			if (hold != 0) begin
				rsp_ch.ready <= 1'b0;
				hold--;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// Drive one request transaction. Valid is only dropped at the start of a gap, so
	// back-to-back transactions keep it high across the accepting edge.
	task automatic send_req(input cmd_t cmd, input logic [TADDR_W-1:0] addr,
			input logic [BYTE_W-1:0] data, input logic [CLUSTER_W-1:0] start);
		int unsigned gap;
		gap = pick_gap();
		if (gap != 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid         <= 1'b1;
		req_ch.cmd           <= cmd;
		req_ch.table_addr    <= addr;
		req_ch.table_byte    <= data;
		req_ch.start_cluster <= start;
		do
			@(posedge clk);
		while (req_ch.ready !== 1'b1);
		sb.note_request(cmd, addr, data, start);
		req_count++;
	endtask

	// Unused fields of a transaction carry random bits so every input bit toggles.
	task automatic load_byte(input logic [TADDR_W-1:0] addr, input logic [BYTE_W-1:0] data);
		send_req(CMD_LOAD, addr, data, CLUSTER_W'($urandom));
	endtask

	// Skip any walk that would read a table byte never loaded.
	task automatic walk_from(input logic [CLUSTER_W-1:0] start);
		if (sb.chain_is_loaded(start))
			send_req(CMD_WALK, TADDR_W'($urandom), BYTE_W'($urandom), start);
	endtask

	// Write one 12-bit FAT entry as two byte loads, keeping the neighbor's nibble.
	task automatic set_entry(input logic [CLUSTER_W-1:0] c, input logic [CLUSTER_W-1:0] v);
		int unsigned off;
		logic [BYTE_W-1:0] lo;
		logic [BYTE_W-1:0] hi;
		off = 32'(c) * 3 / 2;
		lo = sb.loaded[off] ? sb.fat_bytes[off] : BYTE_W'($urandom);
		hi = sb.loaded[off + 1] ? sb.fat_bytes[off + 1] : BYTE_W'($urandom);
		if (c[0]) begin
			lo[7:4] = v[3:0];
			hi = v[11:4];
		end else begin
			lo = v[7:0];
			hi[3:0] = v[11:8];
		end
		load_byte(TADDR_W'(off), lo);
		load_byte(TADDR_W'(off + 1), hi);
		used_clusters.push_back(c);
	endtask

	// Link len distinct clusters below the end mark into one chain closed by an end mark.
	task automatic build_chain(input int unsigned len);
		bit taken [1 << CLUSTER_W];
		logic [CLUSTER_W-1:0] cand;
		chain_nodes.delete();
		while (chain_nodes.size() < len) begin
			cand = CLUSTER_W'($urandom_range(0, END_MARK - 1));
			if (!taken[cand]) begin
				taken[cand] = 1'b1;
				chain_nodes.push_back(cand);
			end
		end
		for (int i = 0; i < len; i++)
			set_entry(chain_nodes[i], (i + 1 < len) ? chain_nodes[i + 1] :
				CLUSTER_W'($urandom_range(END_MARK, MASK12)));
	endtask

	// Hold the request side until every predicted visit is back, then let the walker settle.
	task automatic drain();
		req_ch.valid <= 1'b0;
		while (sb.visits_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic put_reg(input reg_idx_t idx, input logic [LBA_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		sb.write_reg(idx, value);
	endtask

	// Registers change only while the walker is idle.
	task automatic write_config(input logic [LBA_W-1:0] lba, input logic [SPC_W-1:0] spc);
		drain();
		put_reg(REG_DATA_START, lba);
		put_reg(REG_SPC, LBA_W'(spc));
		cfg_we <= 1'b0;
	endtask

	// One step of the random part: in half the draws fresh well-formed chains walked from the head,
	// the rest rewalks, corrupted entries, stray loads and pauses.
	task automatic random_action();
		calm = ($urandom_range(0, 3) == 0);
		case ($urandom_range(0, 11))
		0, 1, 2, 3, 4, 5: begin
			build_chain(($urandom_range(0, 7) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6));
			walk_from(chain_nodes[0]);
			if (chain_nodes.size() > 1 && $urandom_range(0, 1) == 1)
				walk_from(chain_nodes[$urandom_range(1, chain_nodes.size() - 1)]);
		end
		6, 7: walk_from(used_clusters[$urandom_range(0, used_clusters.size() - 1)]);
		8: walk_from(CLUSTER_W'($urandom));
		9: set_entry(used_clusters[$urandom_range(0, used_clusters.size() - 1)],
			CLUSTER_W'($urandom));
		10: load_byte(TADDR_W'($urandom), BYTE_W'($urandom));
		default: drain();
		endcase
	endtask

	initial begin : stimulus
		int unsigned phase_end;
		arst_n               <= 1'b0;
		cfg_we               <= 1'b0;
		cfg_idx              <= REG_DATA_START;
		cfg_wdata            <= '0;
		req_ch.valid         <= 1'b0;
		req_ch.cmd           <= CMD_LOAD;
		req_ch.table_addr    <= '0;
		req_ch.table_byte    <= '0;
		req_ch.start_cluster <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part under reset register values.
		// Top byte of the store: written, never read by any walk.
		load_byte(TADDR_W'(TABLE_BYTES_DEF - 1), 8'hFF);
		// Clusters 0 and 1 end at once; their sector addresses wrap below the data start.
		set_entry(12'h000, 12'hFFF);
		set_entry(12'h001, END_MARK);
		// 2 -> 3 -> FF7 -> 0: the value just below the end mark is an ordinary link.
		set_entry(12'h002, 12'h003);
		set_entry(12'h003, 12'hFF7);
		set_entry(12'hFF7, 12'h000);
		// Start clusters at or above the end mark are still visited once.
		set_entry(12'hFF8, 12'h002);
		set_entry(12'hFFF, END_MARK);
		// Self loop: the walk is cut at the chain bound and flagged.
		set_entry(12'h005, 12'h005);
		walk_from(12'h000);
		walk_from(12'h001);
		walk_from(12'h002);
		walk_from(12'hFF8);
		walk_from(12'hFFF);
		walk_from(12'h005);

		// Random part in phases, each under its own register setting.
		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
			0: write_config(32'hFFFF_FFFF, 8'd128);
			1: write_config(32'd0, 8'd255);
			2: write_config(LBA_W'($urandom), 8'd0);
			3: write_config(DATA_START_RST, SPC_RST);
			default: write_config(LBA_W'($urandom), SPC_W'($urandom_range(1, 128)));
			endcase
			if (phase == 0) begin
				// One chain a cluster longer than the bound: from the head it is cut,
				// from the second node it ends exactly at the bound without the flag.
				calm = 1'b0;
				build_chain(MAX_CHAIN_DEF + 1);
				walk_from(chain_nodes[0]);
				walk_from(chain_nodes[1]);
			end
			phase_end = req_count + 4;
			while (req_count < phase_end)
				random_action();
		end

		drain();
		sb.check_drained();
		if (sb.mismatches == 0)
			$display("fat12_cluster_chain_walker_core regression: pass");
		else
			$display("fat12_cluster_chain_walker_core regression: fail");
		$finish;
	end
endmodule
